FILE: rtl/lrc_pkg.sv
// Shared types and constants of the LRU result cache.
// Request and response words, controller commands and status, state codes.
// No dependencies.
`default_nettype none

package lrc_pkg;

  localparam int KEY_W  = 64;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 32;

  // operation codes carried in the func field
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key_tag;
    logic [VAL_W-1:0] value_in;
  } lrc_req_t;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  value_out;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [STAT_W-1:0] lookup_count;
    logic [STAT_W-1:0] hit_count;
  } lrc_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_UPDATE,
    ST_REPORT
  } lrc_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture request word, clear search results
    logic scan;    // run the tag and rank search pass
    logic apply;   // hit/insert decision and key/value writes
    logic update;  // run the rank aging pass
    logic finish;  // register the response word
  } lrc_ctl_t;

  typedef struct packed {
    logic pass_done;
  } lrc_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lru_result_cache.sv
// Top level of the fully associative LRU result cache.
// Depends on lrc_pkg, lrc_ctrl, lrc_datapath (and lrc_ram below it).
//
//   channel   ports            handshake
//   request   req (lrc_req_t)  taken at a clock edge with start high, busy low
//   response  rsp (lrc_rsp_t)  valid for the one cycle that done is high
//
// Each word runs a search pass and a rank aging pass, and a new word is taken
// only after done for the last one: both passes walk every entry through the single
// read port of the key and rank memories, one entry per cycle.
// Synchronous reset clears the valid bits, counters and controller; no
// memory clearing pass is needed. The response side cannot stall.
`default_nettype none

module lru_result_cache #(
  parameter int CAPACITY = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire lrc_pkg::lrc_req_t req,
  output logic                   busy,
  output logic                   done,
  output lrc_pkg::lrc_rsp_t      rsp
);

  import lrc_pkg::*;

  lrc_ctl_t  ctl;
  lrc_stat_t stat;

  lrc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  lrc_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .req  (req),
    .stat (stat),
    .rsp  (rsp)
  );

  // a word in flight keeps the block busy through its response
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // eviction only comes from a put that missed
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.evicted) |-> !rsp.hit)
    else $error("eviction reported on a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.hit) |-> (rsp.value_out == '0))
    else $error("value returned on a miss");

endmodule

`default_nettype wire

FILE: rtl/lrc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
`default_nettype none

module lrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lrc_ctrl.sv
// Sequencing controller of the LRU result cache.
// Depends on lrc_pkg (state enum, command and status structs).
`default_nettype none

module lrc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire lrc_pkg::lrc_stat_t stat,
  output lrc_pkg::lrc_ctl_t      ctl,
  output logic                   busy,
  output logic                   done
);

  import lrc_pkg::*;

  lrc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.pass_done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        ctl.apply  = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
        if (stat.pass_done) begin
          ctl.finish = 1'b1;
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lrc_datapath.sv
// Datapath of the LRU result cache: key, value and rank memories, valid
// bits, the entry pass pipeline, search registers and counters.
// Depends on lrc_pkg and lrc_ram.
`default_nettype none

module lrc_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lrc_pkg::lrc_ctl_t  ctl,
  input  wire lrc_pkg::lrc_req_t  req,
  output lrc_pkg::lrc_stat_t      stat,
  output lrc_pkg::lrc_rsp_t       rsp
);

  import lrc_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CAPACITY);

  // pass pipeline: cnt issues reads, pend_* tracks the entry whose data is back
  logic [CNT_W-1:0] cnt;
  logic             pend_vld;
  logic [IDX_W-1:0] pend_idx;
  logic             issue;

  logic [CAPACITY-1:0] valid;
  logic [STAT_W-1:0]   lookups;
  logic [STAT_W-1:0]   hits;

  lrc_req_t req_q;

  // search results
  logic             match_found, vic_found, free_found;
  logic [IDX_W-1:0] match_idx, vic_idx, free_idx;
  logic [IDX_W-1:0] match_rank, vic_rank;
  logic [KEY_W-1:0] vic_key;

  // rank update plan
  logic             upd_en, upd_all;
  logic [IDX_W-1:0] upd_target, upd_old;

  logic             hit_q, evict_q;
  logic [KEY_W-1:0] evkey_q;

  // memory ports
  logic             key_we, key_re, val_we, val_re, rank_we, rank_re;
  logic [IDX_W-1:0] key_waddr, val_waddr, val_raddr, rank_waddr, rd_addr;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [IDX_W-1:0] rank_rd, rank_wdata;

  logic             is_get, ins;
  logic [IDX_W-1:0] slot;
  logic             pend_valid, key_eq;

  assign is_get     = (req_q.func == FUNC_GET);
  assign ins        = !is_get && !match_found;
  assign slot       = free_found ? free_idx : vic_idx;
  assign issue      = (ctl.scan || ctl.update) && (cnt < CNT_END);
  assign rd_addr    = cnt[IDX_W-1:0];
  assign pend_valid = valid[pend_idx];
  assign key_eq     = (key_rd == req_q.key_tag);

  assign stat.pass_done = (cnt == CNT_END) && !pend_vld;

  always_comb begin
    key_re     = ctl.scan && (cnt < CNT_END);
    rank_re    = issue;
    key_we     = ctl.apply && ins;
    key_waddr  = slot;
    val_we     = ctl.apply && !is_get;
    val_waddr  = match_found ? match_idx : slot;
    val_re     = ctl.apply && is_get && match_found;
    val_raddr  = match_idx;
    rank_waddr = pend_idx;
    rank_we    = 1'b0;
    rank_wdata = '0;
    if (ctl.update && pend_vld && upd_en) begin
      if (pend_idx == upd_target) begin
        rank_we = 1'b1;
      end else if (pend_valid && (upd_all || rank_rd < upd_old)) begin
        rank_we    = 1'b1;
        rank_wdata = rank_rd + 1'b1;
      end
    end
  end

  lrc_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (req_q.key_tag),
    .re    (key_re),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lrc_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (req_q.value_in),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rd)
  );

  lrc_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .re    (rank_re),
    .raddr (rd_addr),
    .rdata (rank_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      pend_vld    <= 1'b0;
      valid       <= '0;
      lookups     <= '0;
      hits        <= '0;
      match_found <= 1'b0;
      vic_found   <= 1'b0;
      free_found  <= 1'b0;
      upd_en      <= 1'b0;
      upd_all     <= 1'b0;
      hit_q       <= 1'b0;
      evict_q     <= 1'b0;
    end else begin
      if (ctl.load) begin
        cnt         <= '0;
        pend_vld    <= 1'b0;
        match_found <= 1'b0;
        vic_found   <= 1'b0;
        free_found  <= 1'b0;
      end
      if (ctl.scan || ctl.update) begin
        pend_vld <= issue;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (ctl.scan && pend_vld) begin
        if (pend_valid && key_eq && !match_found) begin
          match_found <= 1'b1;
        end
        if (pend_valid && (!vic_found || rank_rd >= vic_rank)) begin
          vic_found <= 1'b1;
        end
        if (!pend_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (ctl.apply) begin
        cnt      <= '0;
        pend_vld <= 1'b0;
        hit_q    <= match_found;
        evict_q  <= ins && !free_found;
        upd_en   <= !is_get || match_found;
        upd_all  <= ins;
        if (is_get) begin
          lookups <= lookups + 1'b1;
          if (match_found) begin
            hits <= hits + 1'b1;
          end
        end
        if (ins) begin
          valid[slot] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= req;
    end
    if (ctl.scan || ctl.update) begin
      if (issue) begin
        pend_idx <= rd_addr;
      end
    end
    if (ctl.scan && pend_vld) begin
      if (pend_valid && key_eq && !match_found) begin
        match_idx  <= pend_idx;
        match_rank <= rank_rd;
      end
      if (pend_valid && (!vic_found || rank_rd >= vic_rank)) begin
        vic_idx  <= pend_idx;
        vic_rank <= rank_rd;
        vic_key  <= key_rd;
      end
      if (!pend_valid && !free_found) begin
        free_idx <= pend_idx;
      end
    end
    if (ctl.apply) begin
      evkey_q    <= vic_key;
      upd_target <= match_found ? match_idx : slot;
      upd_old    <= match_rank;
    end
    if (ctl.finish) begin
      rsp.hit          <= hit_q;
      rsp.value_out    <= (is_get && hit_q) ? val_rd : '0;
      rsp.evicted      <= evict_q;
      rsp.evicted_key  <= evict_q ? evkey_q : '0;
      rsp.lookup_count <= lookups;
      rsp.hit_count    <= hits;
    end
  end

endmodule

`default_nettype wire

FILE: tb/lru_result_cache_tb.sv
// Self-checking testbench for lru_result_cache: directed and random get/put words,
// each response checked against a cycle-free LRU predictor kept in the bench.
// Depends on lrc_pkg and the lru_result_cache RTL.
`timescale 1ns / 1ps

module lru_result_cache_tb;
  import lrc_pkg::*;

  localparam int CAPACITY = 16;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int POOL_MAX = 40;

  typedef struct {
    lrc_req_t word;
    int       gap;    // idle cycles before the word is offered
    bit       drain;  // hold until every response has come back
  } queued_word_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  lrc_req_t req = '0;
  logic     busy;
  logic     done;
  lrc_rsp_t rsp;

  queued_word_t word_backlog[$];
  lrc_rsp_t     pending_rsp[$];
  queued_word_t cur_word;
  bit           have_word = 0;
  int           gap_left = 0;
  int           n_total = 0;
  int           n_sent = 0;
  int           n_recv = 0;
  int           n_errors = 0;

  // predictor state
  bit          c_valid[CAPACITY];
  logic [63:0] c_key[CAPACITY];
  logic [31:0] c_value[CAPACITY];
  int          c_rank[CAPACITY];
  int          c_fill = 0;
  logic [31:0] c_lookups = '0;
  logic [31:0] c_hits = '0;

  logic [63:0] key_pool[POOL_MAX];

  lru_result_cache #(.CAPACITY(CAPACITY)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always #6 clk = ~clk;

  // entries newer than idx age by one, idx becomes newest
  function automatic void make_newest(int idx);
    int i;
    for (i = 0; i < CAPACITY; i++) begin
      if (c_valid[i] && i != idx && c_rank[i] < c_rank[idx]) c_rank[i]++;
    end
    c_rank[idx] = 0;
  endfunction

  function automatic lrc_rsp_t cache_access(lrc_req_t w);
    lrc_rsp_t r;
    int       i;
    int       idx;
    int       slot;
    r = '0;
    idx = -1;
    slot = -1;
    for (i = 0; i < CAPACITY; i++) begin
      if (idx < 0 && c_valid[i] && c_key[i] == w.key_tag) idx = i;
    end
    if (w.func == FUNC_GET) begin
      c_lookups++;
      if (idx >= 0) begin
        c_hits++;
        r.hit = 1'b1;
        r.value_out = c_value[idx];
        make_newest(idx);
      end
    end else if (idx >= 0) begin
      r.hit = 1'b1;
      c_value[idx] = w.value_in;
      make_newest(idx);
    end else begin
      if (c_fill < CAPACITY) begin
        for (i = 0; i < CAPACITY; i++) begin
          if (slot < 0 && !c_valid[i]) slot = i;
        end
      end else begin
        // full: victim is the oldest entry, later index wins a tie
        for (i = 0; i < CAPACITY; i++) begin
          if (c_valid[i] && (slot < 0 || c_rank[i] >= c_rank[slot])) slot = i;
        end
        r.evicted = 1'b1;
        r.evicted_key = c_key[slot];
        c_valid[slot] = 0;
        c_fill--;
      end
      for (i = 0; i < CAPACITY; i++) begin
        if (c_valid[i]) c_rank[i]++;
      end
      c_valid[slot] = 1;
      c_key[slot] = w.key_tag;
      c_value[slot] = w.value_in;
      c_rank[slot] = 0;
      c_fill++;
    end
    r.lookup_count = c_lookups;
    r.hit_count = c_hits;
    return r;
  endfunction

  // driver: one word in flight on the request side, start held until taken
  always @(posedge clk) begin : drive
    logic nxt_start;
    if (rst) begin
      start <= 1'b0;
      req <= '0;
      have_word = 0;
    end else begin
      nxt_start = start;
      if (done) n_recv++;
      if (start && !busy) begin
        pending_rsp.insert(pending_rsp.size(), cache_access(req));
        n_sent++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (!have_word && word_backlog.size() != 0) begin
          cur_word = word_backlog[0];
          word_backlog.delete(0);
          have_word = 1;
          gap_left = cur_word.gap;
        end
        if (have_word) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!(cur_word.drain && n_sent != n_recv)) begin
            req <= cur_word.word;
            nxt_start = 1'b1;
            have_word = 0;
          end
        end
      end
      start <= nxt_start;
    end
  end

  // monitor: every done cycle carries one response word
  always @(posedge clk) begin : check
    lrc_rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected response word: %p", rsp);
      end else begin
        want = pending_rsp[0];
        pending_rsp.delete(0);
        if (rsp.hit !== want.hit || rsp.value_out !== want.value_out ||
            rsp.evicted !== want.evicted || rsp.evicted_key !== want.evicted_key ||
            rsp.lookup_count !== want.lookup_count || rsp.hit_count !== want.hit_count) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch at %0t: exp hit=%0b val=%h ev=%0b evkey=%h lk=%0d hc=%0d",
                     $realtime, want.hit, want.value_out, want.evicted, want.evicted_key,
                     want.lookup_count, want.hit_count);
            $display("                 got hit=%0b val=%h ev=%0b evkey=%h lk=%0d hc=%0d",
                     rsp.hit, rsp.value_out, rsp.evicted, rsp.evicted_key,
                     rsp.lookup_count, rsp.hit_count);
          end
        end
      end
    end
  end

  task automatic add_word(logic func, logic [63:0] key, logic [31:0] val, int gap,
                          bit drain);
    queued_word_t q;
    q.word.func = func;
    q.word.key_tag = key;
    q.word.value_in = val;
    q.gap = gap;
    q.drain = drain;
    word_backlog.insert(word_backlog.size(), q);
    n_total++;
  endtask

  initial begin
    int          i;
    int          phase;
    int          idle_pct;
    int          pool_size;
    int          gap;
    logic        func;
    logic [63:0] key;
    logic [31:0] val;

    for (i = 0; i < CAPACITY; i++) begin
      c_valid[i] = 0;
      c_key[i] = '0;
      c_value[i] = '0;
      c_rank[i] = 0;
    end
    for (i = 0; i < POOL_MAX; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;

    // directed: empty miss, key/value extremes, hit, update, fill, evict
    add_word(FUNC_GET, 64'h0, 32'h0, 0, 0);
    add_word(FUNC_PUT, 64'h0, 32'hFFFF_FFFF, 0, 0);
    add_word(FUNC_PUT, '1, 32'h0, 0, 0);
    add_word(FUNC_GET, 64'h0, 32'h5555_5555, 0, 0);
    add_word(FUNC_GET, '1, 32'hAAAA_AAAA, 0, 0);
    add_word(FUNC_PUT, 64'h0, 32'h1234_5678, 0, 0);
    add_word(FUNC_GET, 64'h0, 32'h0, 0, 0);
    add_word(FUNC_GET, 64'h5, 32'h0, 0, 0);
    for (i = 1; i <= CAPACITY - 2; i++) add_word(FUNC_PUT, 64'(i), 32'(i * 3), 0, 0);
    add_word(FUNC_PUT, 64'd100, 32'hDEAD_BEEF, 0, 0);
    add_word(FUNC_PUT, 64'd7, 32'h7777_0007, 0, 0);
    add_word(FUNC_GET, '1, 32'h0, 0, 0);

    // random: no gaps, 67% of words after a gap, no gaps, 23% of words after a gap
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  pool_size = 18; end
        1: begin idle_pct = 67; pool_size = 24; end
        2: begin idle_pct = 0;  pool_size = 16; end
        default: begin idle_pct = 23; pool_size = POOL_MAX; end
      endcase
      for (i = 0; i < 425; i++) begin
        func = ($urandom_range(99) < 55) ? FUNC_GET : FUNC_PUT;
        if ($urandom_range(99) < 75) key = key_pool[$urandom_range(pool_size - 1)];
        else key = {$urandom, $urandom};
        case ($urandom_range(9))
          0: val = '0;
          1: val = '1;
          default: val = $urandom;
        endcase
        // gaps reach past a full word period so starts land on every busy phase
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 45) : 0;
        add_word(func, key, val, gap, i == 0 || $urandom_range(199) == 0);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (n_recv < n_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_errors += pending_rsp.size();
    if (n_errors == 0) begin
      $display("lru_result_cache_tb OK");
    end else begin
      $display("lru_result_cache_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("lru_result_cache_tb NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/lrc_pkg.sv
rtl/lrc_ram.sv
rtl/lrc_ctrl.sv
rtl/lrc_datapath.sv
rtl/lru_result_cache.sv
tb/lru_result_cache_tb.sv
